// ===== rtl/core/dpac_pkg.sv =====
// Shared types and constants for the dithered pixel to ANSI color stream.
`timescale 1ns / 1ps
package dpac_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CHAN_W    = 16;
    localparam int PROD_W    = CHAN_W + 4;
    localparam int LEVEL_W   = 4;
    localparam int TABLE_AW  = 3 * LEVEL_W;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int WORD_W    = 8;
    localparam int SEQ_MAX   = 11;
    localparam int SEQ_CNT_W = 4;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t               op;
        logic [TABLE_AW-1:0]   addr;
        logic [WORD_W-1:0]     word;
    } stage_t;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;

    localparam logic [4:0] FG_RESET = 5'd31;
    localparam logic [3:0] BG_RESET = 4'd15;

endpackage

// ===== rtl/core/dpac_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module dpac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dpac_quant.sv =====
// Input stage: dithered quantization of the three channels into a table address.
`timescale 1ns / 1ps
module dpac_quant (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dpac_pkg::opcode_t             opcode,
    input  logic [dpac_pkg::CHAN_W-1:0]   red,
    input  logic [dpac_pkg::CHAN_W-1:0]   green,
    input  logic [dpac_pkg::CHAN_W-1:0]   blue,
    input  logic [1:0]                    dither_col,
    input  logic [1:0]                    dither_row,
    input  logic [dpac_pkg::TABLE_AW-1:0] table_index,
    input  logic [dpac_pkg::WORD_W-1:0]   table_word,
    input  logic                          issue,
    output logic                          stage_valid,
    output dpac_pkg::stage_t              stage
);

    localparam logic [4:0] BAYER [16] = '{
        5'd1,  5'd9,  5'd3,  5'd11,
        5'd13, 5'd5,  5'd15, 5'd7,
        5'd4,  5'd12, 5'd2,  5'd10,
        5'd16, 5'd8,  5'd14, 5'd6
    };

    function automatic logic [dpac_pkg::LEVEL_W-1:0] quantize(
        input logic [dpac_pkg::CHAN_W-1:0] chan,
        input logic [4:0]                  bayer
    );
        logic [dpac_pkg::PROD_W-1:0] v;
        logic [dpac_pkg::PROD_W-1:0] off;
        logic [dpac_pkg::PROD_W-1:0] q;
        v   = ({4'b0, chan} << 4) - {4'b0, chan};
        off = dpac_pkg::PROD_W'(bayer) << (dpac_pkg::FRAC_BITS - 3);
        q   = (v - off) >> dpac_pkg::FRAC_BITS;
        if (v <= off)
        begin
            quantize = '0;
        end
        else if (q > dpac_pkg::PROD_W'(15))
        begin
            quantize = 4'd15;
        end
        else
        begin
            quantize = q[dpac_pkg::LEVEL_W-1:0];
        end
    endfunction

    logic                    valid_reg;
    logic                    valid_next;
    dpac_pkg::stage_t        stage_reg;
    dpac_pkg::stage_t        stage_next;
    logic [4:0]              bayer;
    logic                    accept;

    assign in_ready = !valid_reg || issue;
    assign accept   = in_valid && in_ready;
    assign bayer    = BAYER[{dither_row, dither_col}];

    always_comb
    begin
        stage_next      = stage_reg;
        stage_next.op   = opcode;
        stage_next.word = table_word;
        if (opcode == dpac_pkg::OP_LOAD)
        begin
            stage_next.addr = table_index;
        end
        else
        begin
            stage_next.addr = {quantize(blue, bayer), quantize(green, bayer),
                               quantize(red, bayer)};
        end
    end

    assign valid_next = accept ? 1'b1 : (issue ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== rtl/core/dpac_emit.sv =====
// Escape sequence builder and byte shifter, holding the current attributes.
`timescale 1ns / 1ps
module dpac_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        entry_valid,
    output logic                        entry_ready,
    input  logic [dpac_pkg::WORD_W-1:0] entry,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last
);

    logic [7:0]                     buf_reg [dpac_pkg::SEQ_MAX];
    logic [7:0]                     buf_next [dpac_pkg::SEQ_MAX];
    logic [dpac_pkg::SEQ_CNT_W-1:0] rem_reg;
    logic [dpac_pkg::SEQ_CNT_W-1:0] rem_next;
    logic [4:0]                     fg_reg;
    logic [4:0]                     fg_next;
    logic [3:0]                     bg_reg;
    logic [3:0]                     bg_next;

    logic [7:0]                     seq [dpac_pkg::SEQ_MAX];
    logic [dpac_pkg::SEQ_CNT_W-1:0] seq_len;
    logic [4:0]                     fg;
    logic [2:0]                     bg;
    logic                           bg_change;
    logic                           load;
    logic                           shift;

    assign fg        = entry[4:0];
    assign bg        = entry[7:5];
    assign bg_change = ({1'b0, bg} != bg_reg);

    assign out_valid   = (rem_reg != '0);
    assign out_last    = (rem_reg == dpac_pkg::SEQ_CNT_W'(1));
    assign out_byte    = buf_reg[0];
    assign shift       = out_valid && out_ready;
    assign entry_ready = !out_valid || (out_last && out_ready);
    assign load        = entry_valid && entry_ready;

    always_comb
    begin
        for (int i = 0; i < dpac_pkg::SEQ_MAX; i++)
        begin
            seq[i] = dpac_pkg::CH_SPACE;
        end
        seq_len = '0;
        if (fg == {2'b00, bg})
        begin
            if (bg_change)
            begin
                seq[seq_len] = dpac_pkg::CH_ESC;   seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_LBR;   seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_FOUR;  seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_ZERO + {5'b0, bg};
                seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_M;     seq_len = seq_len + 1'b1;
            end
            seq[seq_len] = dpac_pkg::CH_SPACE;     seq_len = seq_len + 1'b1;
        end
        else
        begin
            if (fg == fg_reg)
            begin
                if (bg_change)
                begin
                    seq[seq_len] = dpac_pkg::CH_ESC;   seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_LBR;   seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_FOUR;  seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_ZERO + {5'b0, bg};
                    seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_M;     seq_len = seq_len + 1'b1;
                end
            end
            else
            begin
                seq[seq_len] = dpac_pkg::CH_ESC;       seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_LBR;       seq_len = seq_len + 1'b1;
                if (fg[3] != fg_reg[3])
                begin
                    seq[seq_len] = fg[3] ? dpac_pkg::CH_ONE : dpac_pkg::CH_ZERO;
                    seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_SEMI;  seq_len = seq_len + 1'b1;
                end
                if (bg_change || (fg[3] == 1'b0 && fg_reg[3] == 1'b1))
                begin
                    seq[seq_len] = dpac_pkg::CH_FOUR;  seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_ZERO + {5'b0, bg};
                    seq_len = seq_len + 1'b1;
                    seq[seq_len] = dpac_pkg::CH_SEMI;  seq_len = seq_len + 1'b1;
                end
                seq[seq_len] = dpac_pkg::CH_THREE;     seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_ZERO + {5'b0, fg[2:0]};
                seq_len = seq_len + 1'b1;
                seq[seq_len] = dpac_pkg::CH_M;         seq_len = seq_len + 1'b1;
            end
            seq[seq_len] = dpac_pkg::CH_HASH;          seq_len = seq_len + 1'b1;
        end
    end

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        fg_next  = fg_reg;
        bg_next  = bg_reg;
        if (load)
        begin
            buf_next = seq;
            rem_next = seq_len;
            bg_next  = {1'b0, bg};
            if (fg != {2'b00, bg})
            begin
                fg_next = fg;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < dpac_pkg::SEQ_MAX - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            fg_reg  <= dpac_pkg::FG_RESET;
            bg_reg  <= dpac_pkg::BG_RESET;
        end
        else
        begin
            rem_reg <= rem_next;
            fg_reg  <= fg_next;
            bg_reg  <= bg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== rtl/core/dithered_pixel_to_ansi_color_stream.sv =====
// Top level: dithered pixel to ANSI color byte stream.
`timescale 1ns / 1ps
// A load transaction (tuser = 1) writes one 8-bit entry of the 4096-entry color table and
// produces no output; a pixel transaction (tuser = 0) is quantized with a 4x4 Bayer offset,
// looks up its background/foreground pair in the table and yields 1 to 11 output bytes,
// the last one flagged by tlast. Items flow through three stages (quantize, table read,
// sequence build) and a new item is taken every cycle as long as the output keeps up; the
// output shifter sends one byte per cycle while m_tready is high, and a pixel holds the
// output until its last byte is sent, while a load uses only the table write port.
// Entries are read in arrival order after any earlier load, so a load is seen by every
// later pixel. The table has no reset: reading an entry never written gives no defined
// colors.
module dithered_pixel_to_ansi_color_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red[15:0], green[31:16], blue[47:32], dither_col[49:48], dither_row[51:50],
    // table_index[63:52], table_word[71:64]
    input  logic [71:0] s_tdata,
    // opcode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic                              stage_valid;
    dpac_pkg::stage_t                  stage;
    logic                              issue;
    logic                              ram_we;
    logic                              ram_re;
    logic [dpac_pkg::WORD_W-1:0]       ram_rdata;
    logic                              rd_valid_reg;
    logic                              rd_valid_next;
    logic                              entry_ready;
    logic                              rd_take;

    dpac_quant u_quant (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (dpac_pkg::opcode_t'(s_tuser)),
        .red         (s_tdata[15:0]),
        .green       (s_tdata[31:16]),
        .blue        (s_tdata[47:32]),
        .dither_col  (s_tdata[49:48]),
        .dither_row  (s_tdata[51:50]),
        .table_index (s_tdata[63:52]),
        .table_word  (s_tdata[71:64]),
        .issue       (issue),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    assign rd_take = rd_valid_reg && entry_ready;
    assign issue   = stage_valid
                     && (stage.op == dpac_pkg::OP_LOAD || !rd_valid_reg || rd_take);
    assign ram_we  = issue && (stage.op == dpac_pkg::OP_LOAD);
    assign ram_re  = issue && (stage.op == dpac_pkg::OP_PIXEL);

    dpac_ram #(
        .WIDTH (dpac_pkg::WORD_W),
        .DEPTH (dpac_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (stage.addr),
        .wdata (stage.word),
        .rdata (ram_rdata)
    );

    assign rd_valid_next = ram_re ? 1'b1 : (rd_take ? 1'b0 : rd_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    dpac_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (rd_valid_reg),
        .entry_ready (entry_ready),
        .entry       (ram_rdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == dpac_pkg::CH_SPACE
                                || m_tdata == dpac_pkg::CH_HASH)
    else $error("final byte of a pixel is not a space or hash");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata != dpac_pkg::CH_SPACE
                                 && m_tdata != dpac_pkg::CH_HASH)
    else $error("space or hash sent before the end of a pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !entry_ready |=> rd_valid_reg && $stable(ram_rdata))
    else $error("table read data lost while the sequence builder is busy");

endmodule
